FILE: rtl/core/rtxi_pkg.sv
// Shared types and constants for the x-parallel ray versus triangle pipeline.
`default_nettype none

package rtxi_pkg;

    // Register stages ahead of the divider: differences, products, weights,
    // partial products, terms, numerator sum, magnitudes, divider operands.
    localparam int FRONT_STAGES = 8;

    // Control flags that travel alongside the divider operands.
    typedef struct packed {
        logic hit;
        logic neg;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/ray_triangle_x_intersect.sv
// Pipelined test of one ray parallel to the x axis against one triangle.
//
// Usage: a request carries the three vertices (ax..cz) and the ray's y and z
// on the input channel (i_valid / o_ready). One result per request leaves on
// the output channel (o_valid / i_ready): o_hit and o_cross_x, the x of the
// crossing in the input fixed-point format, rounded to nearest with ties away
// from zero and saturated; o_cross_x is zero when there is no hit.
// The front end forms the differences, the six products, the three
// weights, the weight-times-x partial products, the numerator and the
// operand magnitudes; the divider then produces one quotient bit per
// stage, and a last stage saturates.
// Throughput: one request per cycle while the receiver is not stalling,
// set by the fully pipelined divider.
// Reset clears only the valid bits; the data registers are left as they are.
// When the receiver stalls, the whole pipeline holds and o_ready falls, so
// nothing is lost or repeated; bubbles are not squeezed out.
`default_nettype none

module ray_triangle_x_intersect #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS-1:0] i_az,
    input  wire logic signed [COORD_BITS-1:0] i_bx,
    input  wire logic signed [COORD_BITS-1:0] i_by_coord,
    input  wire logic signed [COORD_BITS-1:0] i_bz,
    input  wire logic signed [COORD_BITS-1:0] i_cx,
    input  wire logic signed [COORD_BITS-1:0] i_cy,
    input  wire logic signed [COORD_BITS-1:0] i_cz,
    input  wire logic signed [COORD_BITS-1:0] i_ray_y,
    input  wire logic signed [COORD_BITS-1:0] i_ray_z,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_hit,
    output logic signed [COORD_BITS-1:0]      o_cross_x
);
    import rtxi_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int DFW  = N + 1;         // difference width
    localparam int PW   = 2 * N + 2;     // product width
    localparam int WW   = 2 * N + 3;     // weight width
    localparam int LW   = N + 2;         // low slice of a weight
    localparam int HW   = WW - LW;       // high slice of a weight
    localparam int PLW  = LW + 1 + N;    // low partial product width
    localparam int PHW  = HW + N;        // high partial product width
    localparam int NW   = 3 * N + 5;     // numerator width
    localparam int DNW  = 2 * N + 5;     // denominator width
    localparam int QB   = N + 2;         // quotient bits
    localparam int DW   = 3 * N + 8;     // divider datapath width
    localparam int NSTG = FRONT_STAGES + QB + 1;

    // The quotient is scale free, so the fraction width only names the format.
    localparam int FRAC_UNUSED = FRAC_BITS;

    logic            en;
    logic [NSTG-1:0] r_v;

    // The pipeline moves as one unit whenever the output register is free.
    assign en      = !r_v[NSTG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // Stage 1: offsets of the vertices from the ray in the y-z plane.
    logic signed [DFW-1:0] r1_ady, r1_adz, r1_bdy, r1_bdz, r1_cdy, r1_cdz;
    logic signed [N-1:0]   r1_ax, r1_bx, r1_cx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ady <= DFW'(i_ay) - DFW'(i_ray_y);
            r1_adz <= DFW'(i_az) - DFW'(i_ray_z);
            r1_bdy <= DFW'(i_by_coord) - DFW'(i_ray_y);
            r1_bdz <= DFW'(i_bz) - DFW'(i_ray_z);
            r1_cdy <= DFW'(i_cy) - DFW'(i_ray_y);
            r1_cdz <= DFW'(i_cz) - DFW'(i_ray_z);
            r1_ax  <= i_ax;
            r1_bx  <= i_bx;
            r1_cx  <= i_cx;
        end
    end

    // Stage 2: the six cross products.
    logic signed [PW-1:0] r2_u0, r2_u1, r2_v0, r2_v1, r2_w0, r2_w1;
    logic signed [N-1:0]  r2_ax, r2_bx, r2_cx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_u0 <= PW'(r1_bdz * r1_cdy);
            r2_u1 <= PW'(r1_bdy * r1_cdz);
            r2_v0 <= PW'(r1_cdz * r1_ady);
            r2_v1 <= PW'(r1_cdy * r1_adz);
            r2_w0 <= PW'(r1_adz * r1_bdy);
            r2_w1 <= PW'(r1_ady * r1_bdz);
            r2_ax <= r1_ax;
            r2_bx <= r1_bx;
            r2_cx <= r1_cx;
        end
    end

    // Stage 3: the weights.
    logic signed [WW-1:0] r3_u, r3_v, r3_w;
    logic signed [N-1:0]  r3_ax, r3_bx, r3_cx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_u  <= WW'(r2_u0) - WW'(r2_u1);
            r3_v  <= WW'(r2_v0) - WW'(r2_v1);
            r3_w  <= WW'(r2_w0) - WW'(r2_w1);
            r3_ax <= r2_ax;
            r3_bx <= r2_bx;
            r3_cx <= r2_cx;
        end
    end

    // Stage 4: hit decision, denominator, and each weight times x split into
    // a low and a high partial product.
    logic s4_zero, s4_nu, s4_nv, s4_nw, s4_hit;

    assign s4_zero = (r3_u == '0) && (r3_v == '0) && (r3_w == '0);
    assign s4_nu   = r3_u[WW-1];
    assign s4_nv   = r3_v[WW-1];
    assign s4_nw   = r3_w[WW-1];
    assign s4_hit  = !s4_zero
                   && ((!s4_nu && !s4_nv && !s4_nw) || (s4_nu && s4_nv && s4_nw));

    logic                  r4_hit;
    logic signed [DNW-1:0] r4_den;
    logic signed [PLW-1:0] r4_ul, r4_vl, r4_wl;
    logic signed [PHW-1:0] r4_uh, r4_vh, r4_wh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_hit <= s4_hit;
            r4_den <= DNW'(r3_u) + DNW'(r3_v) + DNW'(r3_w);
            r4_ul  <= PLW'($signed({1'b0, r3_u[LW-1:0]}) * r3_ax);
            r4_vl  <= PLW'($signed({1'b0, r3_v[LW-1:0]}) * r3_bx);
            r4_wl  <= PLW'($signed({1'b0, r3_w[LW-1:0]}) * r3_cx);
            r4_uh  <= PHW'($signed(r3_u[WW-1:LW]) * r3_ax);
            r4_vh  <= PHW'($signed(r3_v[WW-1:LW]) * r3_bx);
            r4_wh  <= PHW'($signed(r3_w[WW-1:LW]) * r3_cx);
        end
    end

    // Stage 5: recombine the partial products into three terms.
    logic                  r5_hit;
    logic signed [DNW-1:0] r5_den;
    logic signed [NW-1:0]  r5_tu, r5_tv, r5_tw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit <= r4_hit;
            r5_den <= r4_den;
            r5_tu  <= (NW'(r4_uh) <<< LW) + NW'(r4_ul);
            r5_tv  <= (NW'(r4_vh) <<< LW) + NW'(r4_vl);
            r5_tw  <= (NW'(r4_wh) <<< LW) + NW'(r4_wl);
        end
    end

    // Stage 6: numerator.
    logic                  r6_hit;
    logic signed [DNW-1:0] r6_den;
    logic signed [NW-1:0]  r6_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_hit <= r5_hit;
            r6_den <= r5_den;
            r6_num <= r5_tu + r5_tv + r5_tw;
        end
    end

    // Stage 7: sign of the quotient and operand magnitudes.
    t_ctl           r7_ctl;
    logic [NW-1:0]  r7_an;
    logic [DNW-1:0] r7_ad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ctl.hit <= r6_hit;
            r7_ctl.neg <= r6_num[NW-1] ^ r6_den[DNW-1];
            r7_an      <= r6_num[NW-1] ? NW'(-r6_num) : NW'(r6_num);
            r7_ad      <= r6_den[DNW-1] ? DNW'(-r6_den) : DNW'(r6_den);
        end
    end

    // Stage 8: rounding is folded in as (2|num| + |den|) / (2|den|).
    t_ctl          r_ctl [QB+1];
    logic [DW-1:0] r_rem [QB+1];
    logic [DW-1:0] r_dv  [QB+1];
    logic [QB-1:0] r_q   [QB+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0] <= r7_ctl;
            r_rem[0] <= (DW'(r7_an) << 1) + DW'(r7_ad);
            r_dv[0]  <= DW'(r7_ad) << 1;
            r_q[0]   <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [DW-1:0] sh;
        logic          ge;

        assign sh = r_dv[j] << B;
        assign ge = r_rem[j] >= sh;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctl[j+1] <= r_ctl[j];
                r_dv[j+1]  <= r_dv[j];
                r_rem[j+1] <= ge ? (r_rem[j] - sh) : r_rem[j];
                r_q[j+1]   <= {r_q[j][QB-2:0], ge};
            end
        end
    end

    // Output stage: saturate to the coordinate range and apply the sign.
    logic [QB-1:0] q_fin, q_mag, q_max, q_min;
    logic [N-1:0]  res;

    assign q_fin = r_q[QB];
    assign q_max = QB'((QB'(1) << (N - 1)) - QB'(1));
    assign q_min = QB'(1) << (N - 1);

    always_comb begin
        q_mag = q_fin;
        if (!r_ctl[QB].neg) begin
            if (q_fin > q_max) begin
                q_mag = q_max;
            end
            res = q_mag[N-1:0];
        end else begin
            if (q_fin > q_min) begin
                q_mag = q_min;
            end
            res = N'(-q_mag);
        end
        if (!r_ctl[QB].hit) begin
            res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit     <= r_ctl[QB].hit;
            o_cross_x <= res;
        end
    end

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_cross_x == '0))
        else $error("miss result carries a nonzero crossing");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready disagrees with output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid)
        else $error("result presented straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-2] && !en) |=> r_v[NSTG-2])
        else $error("pipeline stage lost a request during a stall");
`endif

endmodule

`default_nettype wire
